[design/assert_macros.svh]
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define OFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define OFE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/ofe_pkg.sv]
// shared types and constants of the oled framebuffer engine
`default_nettype none
package ofe_pkg;

	// action codes
	localparam logic [2:0] ACT_FILL  = 3'd0;
	localparam logic [2:0] ACT_PIXEL = 3'd1;
	localparam logic [2:0] ACT_GOTO  = 3'd2;
	localparam logic [2:0] ACT_GLYPH = 3'd3;
	localparam logic [2:0] ACT_FLUSH = 3'd4;

	// bus token kinds
	localparam logic [1:0] TOK_NONE  = 2'd0;
	localparam logic [1:0] TOK_START = 2'd1;
	localparam logic [1:0] TOK_BYTE  = 2'd2;
	localparam logic [1:0] TOK_STOP  = 2'd3;

	// configuration register indexes
	localparam logic [7:0] REG_INVERT  = 8'd0;
	localparam logic [7:0] REG_I2C     = 8'd1;
	localparam logic [7:0] REG_FONT_W  = 8'd2;
	localparam logic [7:0] REG_FONT_H  = 8'd3;

	// refresh sequence bytes
	localparam logic [7:0] CMD_PAGE    = 8'hB0;
	localparam logic [7:0] CMD_COL_LO  = 8'h00;
	localparam logic [7:0] CMD_COL_HI  = 8'h10;
	localparam logic [7:0] CTRL_CMD    = 8'h00;
	localparam logic [7:0] CTRL_DATA   = 8'h40;
	localparam int         CMD_TOKENS  = 15;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  x;
		logic [7:0]  y;
		logic        color;
		logic [15:0] glyph_bits;
		logic [3:0]  glyph_row;
		logic        last_row;
	} ofe_op_t;

	typedef struct packed {
		logic [1:0] token_kind;
		logic [7:0] token_byte;
		logic       master_ack;
		logic       flush_done;
		logic       char_fits;
	} ofe_tok_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_FILL, ST_PCHK, ST_GSETUP, ST_RD, ST_WR,
		ST_GEND, ST_FRD, ST_FTOK, ST_RESP
	} ofe_state_t;

	typedef enum logic [1:0] {
		SRC_SWEEP, SRC_RMW, SRC_FLUSH
	} ofe_src_t;

	typedef struct packed {
		logic     ld_item;
		logic     goto_upd;
		logic     sweep_clr;
		logic     sweep_inc;
		logic     clear_mode;
		logic     mem_we;
		ofe_src_t mem_src;
		logic     glyph_setup;
		logic     col_clr;
		logic     col_inc;
		logic     cursor_adv;
		logic     flush_tok;
		logic     out_load;
	} ofe_cmd_t;

	typedef struct packed {
		logic [2:0] new_action;
		logic       is_pixel;
		logic       sweep_last;
		logic       on_screen;
		logic       draw_go;
		logic       col_last;
		logic       out_free;
	} ofe_stat_t;

endpackage
`default_nettype wire

[design/ofe_ram.sv]
// generic single-port ram with registered read
`default_nettype none
module ofe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rd_q <= mem[addr];
	end

	assign rdata = rd_q;
endmodule
`default_nettype wire

[design/ofe_ctrl.sv]
// controller state machine of the framebuffer engine
`default_nettype none
module ofe_ctrl import ofe_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      op_valid,
	output logic           op_ready,
	input  wire ofe_stat_t stat,
	output ofe_cmd_t       cmd
);
	ofe_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.mem_src = SRC_SWEEP;
		op_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_mode = 1'b1;
				cmd.mem_we = 1'b1;
				cmd.sweep_inc = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				op_ready = 1'b1;
				if (op_valid) begin
					cmd.ld_item = 1'b1;
					cmd.sweep_clr = 1'b1;
					cmd.col_clr = 1'b1;
					case (stat.new_action)
						ACT_FILL:  state_d = ST_FILL;
						ACT_PIXEL: state_d = ST_PCHK;
						ACT_GOTO: begin
							cmd.goto_upd = 1'b1;
							state_d = ST_RESP;
						end
						ACT_GLYPH: state_d = ST_GSETUP;
						ACT_FLUSH: state_d = ST_FRD;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_FILL: begin
				cmd.mem_we = 1'b1;
				cmd.sweep_inc = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_RESP;
				end
			end
			ST_PCHK: begin
				state_d = stat.on_screen ? ST_RD : ST_RESP;
			end
			ST_GSETUP: begin
				cmd.glyph_setup = 1'b1;
				state_d = stat.draw_go ? ST_RD : ST_GEND;
			end
			ST_RD: begin
				cmd.mem_src = SRC_RMW;
				state_d = ST_WR;
			end
			ST_WR: begin
				cmd.mem_src = SRC_RMW;
				// pixels off the screen are skipped
				cmd.mem_we = stat.on_screen;
				if (stat.is_pixel) begin
					state_d = ST_RESP;
				end else if (stat.col_last) begin
					state_d = ST_GEND;
				end else begin
					cmd.col_inc = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_GEND: begin
				cmd.cursor_adv = 1'b1;
				state_d = ST_RESP;
			end
			ST_FRD: begin
				cmd.mem_src = SRC_FLUSH;
				state_d = ST_FTOK;
			end
			ST_FTOK: begin
				cmd.mem_src = SRC_FLUSH;
				cmd.flush_tok = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[design/ofe_dpath.sv]
// datapath: config, cursor, frame store access, refresh tokens, result register
`default_nettype none
module ofe_dpath import ofe_pkg::*; #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ofe_op_t    op,
	input  wire logic       cfg_valid,
	input  wire logic [7:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire ofe_cmd_t   cmd,
	output ofe_stat_t       stat,
	output logic            tok_valid,
	input  wire logic       tok_ready,
	output ofe_tok_t        tok
);
	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_SIZE  = SCREEN_WIDTH * PAGE_COUNT;
	localparam int AW          = $clog2(STORE_SIZE);
	localparam int PAGE_TOKENS = CMD_TOKENS + 4 + SCREEN_WIDTH;
	localparam int PW          = $clog2(PAGE_TOKENS + 1);

	ofe_op_t        item_q;
	logic           inv_q;
	logic [6:0]     i2c_q;
	logic [4:0]     fw_q, fh_q;
	logic [7:0]     ccol_q, crow_q;
	logic           fits_q;
	logic [2:0]     fpage_q;
	logic [PW-1:0]  fpos_q;
	logic [AW-1:0]  sweep_q;
	logic [4:0]     col_q;
	ofe_tok_t       res_q, tok_q, tok_next;
	logic           tok_valid_q;

	logic           is_pixel, glyph_bit, pix_color, wr_color;
	logic [8:0]     px, py;
	logic [AW-1:0]  rmw_addr, flush_addr, mem_addr;
	logic [7:0]     mem_wdata, mem_rdata, mask, addr_byte, cmd_byte;
	logic           fits_calc, fits_new;
	logic [PW-1:0]  q, pos_inc;
	logic [2:0]     k;

	assign is_pixel = (item_q.action == ACT_PIXEL);

	// pixel coordinate: item for a pixel write, cursor plus column for a glyph row
	always_comb begin
		if (is_pixel) begin
			px = {1'b0, item_q.x};
			py = {1'b0, item_q.y};
		end else begin
			px = {1'b0, ccol_q} + {4'b0, col_q};
			py = {1'b0, crow_q} + {5'b0, item_q.glyph_row};
		end
		glyph_bit = (col_q < 5'd16) ? item_q.glyph_bits[4'd15 - col_q[3:0]] : 1'b0;
		pix_color = is_pixel ? item_q.color : (glyph_bit ? item_q.color : ~item_q.color);
		wr_color = pix_color ^ inv_q;
		mask = 8'(1) << py[2:0];
	end

	assign rmw_addr = AW'(int'(py[5:3]) * SCREEN_WIDTH + int'(px));

	// refresh position within the page
	assign q = fpos_q - PW'(CMD_TOKENS);
	assign flush_addr = AW'(int'(fpage_q) * SCREEN_WIDTH + int'(q) - 3);
	assign pos_inc = fpos_q + PW'(1);
	assign addr_byte = {i2c_q, 1'b0};

	always_comb begin
		case (cmd.mem_src)
			SRC_RMW: begin
				mem_addr = rmw_addr;
				mem_wdata = wr_color ? (mem_rdata | mask) : (mem_rdata & ~mask);
			end
			SRC_FLUSH: begin
				mem_addr = flush_addr;
				mem_wdata = mem_rdata;
			end
			default: begin
				mem_addr = sweep_q;
				mem_wdata = cmd.clear_mode ? 8'h00 : {8{item_q.color}};
			end
		endcase
	end

	ofe_ram #(.WIDTH(8), .DEPTH(STORE_SIZE)) u_ram (
		.clk   (clk),
		.we    (cmd.mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// fit check and glyph draw decision
	always_comb begin
		fits_calc = (({1'b0, ccol_q} + 9'(fw_q)) < 9'(SCREEN_WIDTH)) &&
			(({1'b0, crow_q} + 9'(fh_q)) < 9'(SCREEN_HEIGHT));
		fits_new = (item_q.glyph_row == 4'd0) ? fits_calc : fits_q;
	end

	// next refresh token
	always_comb begin
		tok_next = '0;
		k = 3'd0;
		cmd_byte = CMD_COL_HI;
		if (fpos_q < PW'(CMD_TOKENS)) begin
			if (fpos_q < PW'(5)) begin
				k = 3'(fpos_q);
				cmd_byte = CMD_PAGE + {5'b0, fpage_q};
			end else if (fpos_q < PW'(10)) begin
				k = 3'(fpos_q - PW'(5));
				cmd_byte = CMD_COL_LO;
			end else begin
				k = 3'(fpos_q - PW'(10));
			end
			case (k)
				3'd0: tok_next.token_kind = TOK_START;
				3'd1: begin
					tok_next.token_kind = TOK_BYTE;
					tok_next.token_byte = addr_byte;
				end
				3'd2: begin
					tok_next.token_kind = TOK_BYTE;
					tok_next.token_byte = CTRL_CMD;
				end
				3'd3: begin
					tok_next.token_kind = TOK_BYTE;
					tok_next.token_byte = cmd_byte;
				end
				default: tok_next.token_kind = TOK_STOP;
			endcase
		end else if (q == PW'(0)) begin
			tok_next.token_kind = TOK_START;
		end else if (q == PW'(SCREEN_WIDTH + 3)) begin
			tok_next.token_kind = TOK_STOP;
			tok_next.flush_done = (32'(fpage_q) == 32'(PAGE_COUNT - 1));
		end else begin
			tok_next.token_kind = TOK_BYTE;
			tok_next.master_ack = 1'b1;
			if (q == PW'(1)) begin
				tok_next.token_byte = addr_byte;
			end else if (q == PW'(2)) begin
				tok_next.token_byte = CTRL_DATA;
			end else begin
				tok_next.token_byte = mem_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b0;
			i2c_q <= 7'd60;
			fw_q <= 5'd7;
			fh_q <= 5'd10;
			ccol_q <= '0;
			crow_q <= '0;
			fits_q <= 1'b0;
			fpage_q <= '0;
			fpos_q <= '0;
			sweep_q <= '0;
			col_q <= '0;
			tok_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_INVERT: inv_q <= cfg_data[0];
					REG_I2C:    i2c_q <= cfg_data[6:0];
					REG_FONT_W: fw_q <= cfg_data[4:0];
					REG_FONT_H: fh_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (cmd.goto_upd) begin
				ccol_q <= op.x + 8'd2;
				crow_q <= op.y;
			end
			if (cmd.cursor_adv && item_q.last_row && fits_q) begin
				ccol_q <= ccol_q + {3'b0, fw_q};
			end
			if (cmd.glyph_setup) begin
				fits_q <= fits_new;
			end
			if (cmd.sweep_clr) begin
				sweep_q <= '0;
			end else if (cmd.sweep_inc) begin
				sweep_q <= sweep_q + AW'(1);
			end
			if (cmd.col_clr) begin
				col_q <= '0;
			end else if (cmd.col_inc) begin
				col_q <= col_q + 5'd1;
			end
			if (cmd.flush_tok) begin
				if (32'(pos_inc) >= PAGE_TOKENS) begin
					fpos_q <= '0;
					if (32'(fpage_q) == 32'(PAGE_COUNT - 1)) begin
						fpage_q <= '0;
					end else begin
						fpage_q <= fpage_q + 3'd1;
					end
				end else begin
					fpos_q <= pos_inc;
				end
			end
			if (cmd.out_load) begin
				tok_valid_q <= 1'b1;
			end else if (tok_ready) begin
				tok_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			item_q <= op;
			res_q <= '0;
		end
		if (cmd.glyph_setup) begin
			res_q.char_fits <= fits_new;
		end
		if (cmd.flush_tok) begin
			res_q <= tok_next;
		end
		if (cmd.out_load) begin
			tok_q <= res_q;
		end
	end

	always_comb begin
		stat.new_action = op.action;
		stat.is_pixel = is_pixel;
		stat.sweep_last = (32'(sweep_q) == STORE_SIZE - 1);
		// current pixel lies on the screen, for a pixel write or a glyph column
		stat.on_screen = (px < 9'(SCREEN_WIDTH)) && (py < 9'(SCREEN_HEIGHT));
		stat.draw_go = fits_new && ({1'b0, item_q.glyph_row} < fh_q) && (fw_q != 5'd0);
		stat.col_last = (col_q == fw_q - 5'd1);
		stat.out_free = !tok_valid_q || tok_ready;
	end

	assign tok_valid = tok_valid_q;
	assign tok = tok_q;
endmodule
`default_nettype wire

[design/mono_oled_framebuffer_engine.sv]
// top level of the monochrome oled framebuffer engine
//
// channel | signals                          | word
// op      | op_valid, op_ready, op           | one action (fill, pixel, goto, glyph row, flush)
// tok     | tok_valid, tok_ready, tok        | one result: bus token and glyph fit flag
// cfg     | cfg_valid, cfg_ready, cfg_index  | one register write, cfg_data holds the value
//
// a glyph row draws one pixel per font column and a fill sweeps the whole store;
//   an off-screen pixel write and a glyph row that is not drawn skip the frame store
// the frame store is single-port: each pixel is a read then a write
// after reset a clearing pass writes every byte with op_ready low
// a new word is taken while the previous result waits on tok; a stalled result
//   holds the engine only at its final step
// cfg writes are taken in any cycle
`default_nettype none
module mono_oled_framebuffer_engine import ofe_pkg::*; #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// action words
	input  wire logic       op_valid,
	output logic            op_ready,
	input  wire ofe_op_t    op,
	// result words
	output logic            tok_valid,
	input  wire logic       tok_ready,
	output ofe_tok_t        tok,
	// register writes
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	ofe_cmd_t  cmd;
	ofe_stat_t stat;

	// registers always accept a write
	assign cfg_ready = 1'b1;

	// sequencing of every action
	ofe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage, cursor, refresh counters and the result register
	ofe_dpath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok)
	);
endmodule
`default_nettype wire

[design/ofe_checker.sv]
// port checker of the framebuffer engine and its bind
`default_nettype none
`include "assert_macros.svh"
module ofe_checker import ofe_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     tok_valid,
	input wire logic     tok_ready,
	input wire ofe_tok_t tok
);
	`OFE_ASSERT(a_tok_hold, tok_valid && !tok_ready |=> tok_valid && $stable(tok), "result word dropped while stalled")
	`OFE_ASSERT(a_done_on_stop, tok_valid && tok.flush_done |-> tok.token_kind == TOK_STOP, "refresh done off a stop token")
	`OFE_ASSERT(a_byte_fields, tok_valid && tok.token_kind != TOK_BYTE |-> tok.token_byte == 8'h00 && !tok.master_ack, "byte fields set on a non-byte token")
	`OFE_ASSERT(a_fits_no_token, tok_valid && tok.char_fits |-> tok.token_kind == TOK_NONE, "fit flag on a bus token")
	`OFE_ASSERT_ALWAYS(a_quiet_reset, !arst_n |=> !tok_valid, "result word valid out of reset")
endmodule

bind mono_oled_framebuffer_engine ofe_checker u_ofe_checker (.*);
`default_nettype wire

[tb/sv/tb_mono_oled_framebuffer_engine.sv]
// testbench of the oled framebuffer engine: random and directed actions checked against a predictor
`default_nettype none
module tb_mono_oled_framebuffer_engine;
	import ofe_pkg::*;

	localparam int SW = 128;
	localparam int SH = 64;
	localparam int PAGES = (SH + 7) / 8;
	localparam int STORE = SW * PAGES;
	localparam int PAGE_TOKS = CMD_TOKENS + 4 + SW;
	// clearing pass plus a full fill leaves long quiet stretches
	localparam int STALL_LIMIT = 20000;

	// screen model: frame bytes, cursor, refresh position and register copies
	class oled_scoreboard;
		logic [7:0] frame [STORE];
		logic [7:0] cur_col, cur_row;
		bit fits;
		int page, pos;
		bit inv;
		logic [6:0] addr;
		int fw, fh;
		ofe_tok_t pending [$];
		int errors;

		function void clear();
			foreach (frame[i]) frame[i] = 8'h00;
			cur_col = 0; cur_row = 0; fits = 0; page = 0; pos = 0;
			inv = 0; addr = 7'd60; fw = 7; fh = 10; errors = 0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [7:0] val);
			case (idx)
				REG_INVERT: inv = val[0];
				REG_I2C:    addr = val[6:0];
				REG_FONT_W: fw = val[4:0];
				REG_FONT_H: fh = val[4:0];
				default: ;
			endcase
		endfunction

		function void set_pixel(int px, int py, bit white);
			int idx;
			if (px >= SW || py >= SH) return;
			if (inv) white = !white;
			idx = px + (py / 8) * SW;
			frame[idx][py % 8] = white;
		endfunction

		function ofe_tok_t next_token();
			ofe_tok_t t;
			int k, q;
			logic [7:0] cmd;
			t = '0;
			if (pos < CMD_TOKENS) begin
				k = pos % 5;
				cmd = (pos / 5 == 0) ? CMD_PAGE + 8'(page) :
					(pos / 5 == 1) ? CMD_COL_LO : CMD_COL_HI;
				if (k == 0) t.token_kind = TOK_START;
				else if (k == 4) t.token_kind = TOK_STOP;
				else begin
					t.token_kind = TOK_BYTE;
					t.token_byte = (k == 1) ? {addr, 1'b0} : (k == 2) ? CTRL_CMD : cmd;
				end
			end else begin
				q = pos - CMD_TOKENS;
				if (q == 0) t.token_kind = TOK_START;
				else if (q == SW + 3) t.token_kind = TOK_STOP;
				else begin
					t.token_kind = TOK_BYTE;
					t.master_ack = 1;
					t.token_byte = (q == 1) ? {addr, 1'b0} : (q == 2) ? CTRL_DATA :
						frame[page * SW + q - 3];
				end
			end
			pos++;
			if (pos >= PAGE_TOKS) begin
				pos = 0;
				page++;
				if (page >= PAGES) begin
					page = 0;
					t.flush_done = 1;
				end
			end
			return t;
		endfunction

		// note an accepted action word and queue its result
		function void note_action(ofe_op_t w);
			ofe_tok_t t;
			bit on;
			t = '0;
			case (w.action)
				ACT_FILL: foreach (frame[i]) frame[i] = {8{w.color}};
				ACT_PIXEL: set_pixel(w.x, w.y, w.color);
				ACT_GOTO: begin
					cur_col = w.x + 8'd2;
					cur_row = w.y;
				end
				ACT_GLYPH: begin
					if (w.glyph_row == 0)
						fits = (int'(cur_col) + fw < SW) && (int'(cur_row) + fh < SH);
					if (fits && w.glyph_row < fh)
						for (int j = 0; j < fw; j++) begin
							on = (j < 16) ? w.glyph_bits[15 - j] : 1'b0;
							set_pixel(cur_col + j, cur_row + w.glyph_row,
								on ? w.color : !w.color);
						end
					if (w.last_row && fits) cur_col = cur_col + 8'(fw);
					t.char_fits = fits;
				end
				ACT_FLUSH: t = next_token();
				default: ;
			endcase
			pending.push_back(t);
		endfunction

		// compare one result word with the oldest expectation
		function void check_token(ofe_tok_t got);
			ofe_tok_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %h", $realtime, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.token_kind !== e.token_kind || got.token_byte !== e.token_byte ||
				got.master_ack !== e.master_ack || got.flush_done !== e.flush_done ||
				got.char_fits !== e.char_fits) begin
				$display("%0t: expected kind %0d byte %h ack %b done %b fits %b, got kind %0d byte %h ack %b done %b fits %b",
					$realtime, e.token_kind, e.token_byte, e.master_ack, e.flush_done,
					e.char_fits, got.token_kind, got.token_byte, got.master_ack,
					got.flush_done, got.char_fits);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic op_valid = 0, op_ready;
	ofe_op_t op = '0;
	logic tok_valid, tok_ready = 0;
	ofe_tok_t tok;
	logic cfg_valid = 0, cfg_ready;
	logic [7:0] cfg_index = 0, cfg_data = 0;

	oled_scoreboard sb = new();
	bit idle_on = 1;      // random gaps enabled
	int stall_cnt = 0;

	mono_oled_framebuffer_engine i_dut (
		.clk, .arst_n, .op_valid, .op_ready, .op,
		.tok_valid, .tok_ready, .tok,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	initial begin
		forever #6 clk = !clk;
	end

	// receiver side: random back-pressure, every accepted word is checked
	always @(posedge clk) begin
		if (tok_valid && tok_ready) sb.check_token(tok);
		tok_ready <= idle_on ? ($urandom_range(99) >= 35) : 1'b1;
	end

	// watchdog on cycles with no accepted word on any channel
	always @(posedge clk) begin
		if ((op_valid && op_ready) || (tok_valid && tok_ready) || (cfg_valid && cfg_ready))
			stall_cnt <= 0;
		else if (stall_cnt >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else
			stall_cnt <= stall_cnt + 1;
	end

	// valid stays high into the next word when no gap is drawn
	task automatic send(ofe_op_t w);
		while (idle_on && $urandom_range(99) < 35) begin
			op_valid <= 0;
			@(posedge clk);
		end
		op_valid <= 1;
		op <= w;
		do @(posedge clk); while (!op_ready);
		sb.note_action(w);
	endtask

	// wait until every result is in, then a few quiet cycles
	task automatic drain();
		op_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [7:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic ofe_op_t make(logic [2:0] a, logic [7:0] x, logic [7:0] y,
		logic c, logic [15:0] g, logic [3:0] r, logic l);
		ofe_op_t w;
		w.action = a; w.x = x; w.y = y; w.color = c;
		w.glyph_bits = g; w.glyph_row = r; w.last_row = l;
		return w;
	endfunction

	// a whole glyph with random rows, drawn at the current cursor position
	task automatic draw_char();
		int rows;
		rows = $urandom_range(sb.fh + 1, 1);
		for (int r = 0; r < rows && r < 16; r++)
			send(make(ACT_GLYPH, 8'($urandom), 8'($urandom), 1'($urandom),
				16'($urandom), 4'(r), r == rows - 1 || r == 15));
	endtask

	task automatic random_word();
		int pick;
		ofe_op_t w;
		pick = $urandom_range(99);
		w = make(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
			16'($urandom), 4'($urandom), 1'($urandom));
		if (pick < 2) w.action = ACT_FILL;
		else if (pick < 22) begin
			w.action = ACT_PIXEL;
			if ($urandom_range(3) != 0) begin
				w.x = 8'($urandom_range(SW - 1));
				w.y = 8'($urandom_range(SH - 1));
			end
		end else if (pick < 30) begin
			w.action = ACT_GOTO;
			if ($urandom_range(3) != 0) w.x = 8'($urandom_range(SW - 20));
			if ($urandom_range(3) != 0) w.y = 8'($urandom_range(SH - 18));
		end else if (pick < 48) begin
			draw_char();
			return;
		end else if (pick < 55) w.action = ACT_GLYPH;
		else if (pick < 57) w.action = 3'(5 + $urandom_range(2));
		else w.action = ACT_FLUSH;
		send(w);
	endtask

	task automatic random_cfg();
		write_reg(REG_INVERT, 8'($urandom_range(1)));
		write_reg(REG_I2C, 8'($urandom_range(127)));
		write_reg(REG_FONT_W, 8'($urandom_range(16, 1)));
		write_reg(REG_FONT_H, 8'($urandom_range(16, 1)));
	endtask

	initial begin
		sb.clear();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: fills, pixel corners, off-screen writes, glyph fit and edges
		send(make(ACT_FILL, 0, 0, 1, 0, 0, 0));
		send(make(ACT_PIXEL, 0, 0, 0, 0, 0, 0));
		send(make(ACT_PIXEL, 8'(SW - 1), 8'(SH - 1), 0, 0, 0, 0));
		send(make(ACT_PIXEL, 8'(SW), 0, 0, 0, 0, 0));
		send(make(ACT_PIXEL, 255, 255, 0, 0, 0, 0));
		send(make(ACT_FILL, 0, 0, 0, 0, 0, 0));
		send(make(ACT_GOTO, 255, 255, 0, 0, 0, 0));
		send(make(ACT_GLYPH, 0, 0, 1, 16'hFFFF, 0, 1));
		send(make(ACT_GOTO, 0, 0, 0, 0, 0, 0));
		send(make(ACT_GLYPH, 0, 0, 1, 16'hA5C3, 0, 0));
		send(make(ACT_GLYPH, 0, 0, 0, 16'h0000, 15, 0));
		send(make(ACT_GLYPH, 0, 0, 1, 16'h8001, 9, 1));
		send(make(ACT_GOTO, 8'(SW - 10), 8'(SH - 11), 0, 0, 0, 0));
		send(make(ACT_GLYPH, 0, 0, 1, 16'hFFFF, 0, 1));
		send(make(ACT_PIXEL, 5, 9, 1, 0, 0, 0));
		send(make(3'd7, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 6; i++) send(make(ACT_FLUSH, 0, 0, 0, 0, 0, 0));
		drain();

		// font extremes, inversion and address
		write_reg(REG_INVERT, 1);
		write_reg(REG_I2C, 127);
		write_reg(REG_FONT_W, 16);
		write_reg(REG_FONT_H, 16);
		send(make(ACT_GOTO, 3, 4, 0, 0, 0, 0));
		draw_char();
		send(make(ACT_PIXEL, 1, 1, 1, 0, 0, 0));
		drain();
		write_reg(REG_I2C, 0);
		write_reg(REG_FONT_W, 1);
		write_reg(REG_FONT_H, 1);
		write_reg(REG_INVERT, 0);
		draw_char();

		// random phases; one without any idling, one holds the sender until drained
		for (int ph = 0; ph < 6; ph++) begin
			idle_on = (ph != 2);
			for (int i = 0; i < 30; i++) random_word();
			if (ph == 3) begin
				drain();
				for (int i = 0; i < 20; i++) random_word();
			end
			drain();
			random_cfg();
		end

		// one page of refresh plus two tokens of the next, with random frame content
		write_reg(REG_I2C, 60);
		idle_on = 1;
		for (int i = 0; i < PAGE_TOKS + 2; i++)
			send(make(ACT_FLUSH, 8'($urandom), 8'($urandom), 1'($urandom),
				16'($urandom), 4'($urandom), 1'($urandom)));

		drain();
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
